[src/carriage_ramp_stop_controller_defines.svh]
// ----------------------------------------------------------------------------
// Carriage ramp/stop controller assertion macros
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CARRIAGE_RAMP_STOP_CONTROLLER_DEFINES_SVH
`define CARRIAGE_RAMP_STOP_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, disabled during reset.
`define CRSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("carriage controller check failed");
// Next-cycle implication, clocked on clk, disabled during reset.
`define CRSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("carriage controller check failed");
`else
`define CRSC_ASSERT_SAME(lbl, ante, cons)
`define CRSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/crsc_pkg.sv]
// ----------------------------------------------------------------------------
// Carriage ramp/stop controller package
// Types, register indexes and fixed constants shared by the controller.
// ----------------------------------------------------------------------------
package crsc_pkg;

    // Run state machine, one-hot.
    typedef enum logic [3:0] {
        ST_STOPPED  = 4'b0001,
        ST_RAMP     = 4'b0010,
        ST_TRANSIT  = 4'b0100,
        ST_STOPPING = 4'b1000
    } mode_t;

    // External run state codes.
    localparam logic [1:0] RUN_STOPPED  = 2'd0;
    localparam logic [1:0] RUN_RAMP     = 2'd1;
    localparam logic [1:0] RUN_TRANSIT  = 2'd2;
    localparam logic [1:0] RUN_STOPPING = 2'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ACCEL_FACTOR   = 3'd0,
        REG_CRUISE_LEVEL   = 3'd1,
        REG_BRAKE_SPAN     = 3'd2,
        REG_TIMEOUT_LIMIT  = 3'd3,
        REG_TIMEOUT_ENABLE = 3'd4,
        REG_TEST_MODE      = 3'd5
    } cfg_reg_t;

    // Heading codes, two-bit two's complement.
    localparam logic [1:0] HEAD_NONE = 2'b00;
    localparam logic [1:0] HEAD_FWD  = 2'b01;
    localparam logic [1:0] HEAD_REV  = 2'b11;

    localparam logic [2:0] CODE_OFF = 3'b000;

    // Register reset values.
    localparam logic [7:0]  ACCEL_FACTOR_RESET  = 8'd20;
    localparam logic [7:0]  CRUISE_LEVEL_RESET  = 8'd200;
    localparam logic [31:0] BRAKE_SPAN_RESET    = 32'd8000000;
    localparam logic [31:0] TIMEOUT_LIMIT_RESET = 32'd10000000;
    localparam logic [15:0] RAMP_GAIN_RESET     = 16'd4000;

    // Ramp level divisor and its reciprocal. Numerators below 2^27 divide exactly
    // as a multiplication by RECIP followed by a right shift of RECIP_SHIFT.
    localparam int          LEVEL_NUM_BITS = 27;
    localparam int          RECIP_BITS     = 28;
    localparam int          RECIP_SHIFT    = 46;
    localparam int          DIV_PROD_BITS  = LEVEL_NUM_BITS + RECIP_BITS;
    localparam logic [26:0] RAMP_DIVISOR   = 27'(100000000 >> 8);
    localparam logic [27:0] RECIP          =
        28'(((64'd1 << RECIP_SHIFT) + 64'd390624) / 64'd390625);
    // Numerators of a level below the top speed stay under this bound.
    localparam logic [26:0] LEVEL_NUM_LIMIT = 27'((100000000 >> 8) * 255);

    typedef struct packed {
        logic [7:0]  accel_factor;
        logic [7:0]  cruise_level;
        logic [31:0] brake_span;
        logic [31:0] timeout_limit;
        logic        timeout_enable;
        logic        test_mode;
        logic [15:0] ramp_gain;     // accel_factor * cruise_level
    } cfg_t;

    // Bridge update produced by one tick.
    typedef struct packed {
        logic                      drive;
        logic                      use_level;
        logic [7:0]                speed;
        logic [2:0]                code;
        logic [LEVEL_NUM_BITS-1:0] level_num;
    } drive_cmd_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            ST_STOPPED:  c = RUN_STOPPED;
            ST_RAMP:     c = RUN_RAMP;
            ST_TRANSIT:  c = RUN_TRANSIT;
            ST_STOPPING: c = RUN_STOPPING;
            default:     c = RUN_STOPPED;
        endcase
        return c;
    endfunction

endpackage

[src/crsc_step.sv]
// ----------------------------------------------------------------------------
// Carriage ramp/stop controller tick step
// Next run state, phase timer, heading and pending requests for one tick,
// plus the bridge update that the tick asks for.
// ----------------------------------------------------------------------------
module crsc_step
    import crsc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  cfg_t                 cfg,
    input  mode_t                mode_in,
    input  logic [TIME_BITS-1:0] phase_in,
    input  logic [1:0]           heading_in,
    input  logic                 pend_fwd_in,
    input  logic                 pend_rev_in,
    input  logic [19:0]          elapsed_us,
    input  logic                 at_track_end,
    input  logic                 at_track_start,
    input  logic                 forward_request,
    input  logic                 reverse_request,
    output mode_t                mode_out,
    output logic [TIME_BITS-1:0] phase_out,
    output logic [1:0]           heading_out,
    output logic                 pend_fwd_out,
    output logic                 pend_rev_out,
    output drive_cmd_t           cmd
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS:0]        phase_sum;
    logic [TIME_BITS-1:0]      phase_sat;
    logic [CW-1:0]             sat_ext;
    logic [18:0]               ramp_t;
    logic                      ramp_big;
    logic [26:0]               rate_prod;
    logic [34:0]               gain_prod;
    logic                      reach;

    mode_t                     mode;
    logic [TIME_BITS-1:0]      pt;
    logic [1:0]                hd;
    logic                      pf;
    logic                      pr;
    logic                      stop_req;

    assign phase_sum = {1'b0, phase_in} + (TIME_BITS+1)'(elapsed_us);
    assign phase_sat = phase_sum[TIME_BITS] ? '1 : phase_sum[TIME_BITS-1:0];
    assign sat_ext   = CW'(phase_sat);

    // The ramp reaches top speed exactly when (time>>8) * accel_factor reaches
    // the divisor, so the top speed factor drops out of the comparison.
    assign ramp_t    = sat_ext[26:8];
    assign ramp_big  = |sat_ext[CW-1:27];
    assign rate_prod = 27'(ramp_t) * 27'(cfg.accel_factor);
    assign gain_prod = 35'(ramp_t) * 35'(cfg.ramp_gain);
    assign reach     = (cfg.cruise_level == 8'd0) ||
                       ((cfg.accel_factor != 8'd0) &&
                        (ramp_big || (rate_prod >= RAMP_DIVISOR)));

    always_comb
    begin
        mode     = mode_in;
        pt       = phase_sat;
        hd       = heading_in;
        pf       = pend_fwd_in | forward_request;
        pr       = pend_rev_in | reverse_request;
        stop_req = 1'b0;
        cmd      = '0;

        case (mode_in)
            ST_STOPPED:
            begin
                hd = HEAD_NONE;
            end
            ST_RAMP:
            begin
                cmd.drive = 1'b1;
                cmd.code  = {hd[1], hd};
                if (reach)
                begin
                    mode      = ST_TRANSIT;
                    cmd.speed = cfg.cruise_level;
                end
                else
                begin
                    cmd.use_level = 1'b1;
                    cmd.level_num = gain_prod[LEVEL_NUM_BITS-1:0];
                end
            end
            ST_STOPPING:
            begin
                cmd.drive = 1'b1;
                cmd.code  = {hd, 1'b0};
                if (CW'(pt) >= CW'(cfg.brake_span))
                begin
                    mode     = ST_STOPPED;
                    pt       = '0;
                    cmd.code = CODE_OFF;
                end
            end
            ST_TRANSIT:
            begin
                mode = ST_TRANSIT;
            end
            default:
            begin
                mode = mode_in;
            end
        endcase

        if (mode == ST_TRANSIT || mode == ST_RAMP)
        begin
            stop_req = ((hd == HEAD_FWD) && at_track_end) ||
                       (hd[1] && at_track_start) ||
                       (cfg.timeout_enable && (CW'(pt) >= CW'(cfg.timeout_limit)));
            if (stop_req)
            begin
                pt   = '0;
                mode = ST_STOPPING;
            end
        end

        if (mode == ST_STOPPED)
        begin
            if (cfg.test_mode)
            begin
                // Idle reverse: a non-negative heading asks for reverse.
                if (CW'(pt) >= CW'(cfg.timeout_limit))
                begin
                    if (!hd[1])
                        pr = 1'b1;
                    else
                        pf = 1'b1;
                    pt = '0;
                end
                if (at_track_end)
                begin
                    mode = ST_RAMP;
                    pt   = '0;
                    hd   = HEAD_REV;
                end
                if (at_track_start)
                begin
                    mode = ST_RAMP;
                    pt   = '0;
                    hd   = HEAD_FWD;
                end
            end
            // Forward is served first, so a pending reverse wins.
            if (pf)
            begin
                pf   = 1'b0;
                mode = ST_RAMP;
                pt   = '0;
                hd   = HEAD_FWD;
            end
            if (pr)
            begin
                pr   = 1'b0;
                mode = ST_RAMP;
                pt   = '0;
                hd   = HEAD_REV;
            end
        end
    end

    assign mode_out     = mode;
    assign phase_out    = pt;
    assign heading_out  = hd;
    assign pend_fwd_out = pf;
    assign pend_rev_out = pr;

endmodule

[src/carriage_ramp_stop_controller.sv]
// ----------------------------------------------------------------------------
// Carriage ramp/stop controller
// Four-state carriage drive sequencer: stopped, ramp, transit and stopping.
// ----------------------------------------------------------------------------
// Each item on the tick channel (item_valid / item_stall) is one control tick
// with the elapsed microseconds, the two track sensors and the two requests.
// Every tick gives exactly one result on the result channel (result_valid /
// result_stall): the held bridge level and code, the run state and heading.
// The tick updates the state registers and a command register when it is
// accepted; the ramp level division, a reciprocal multiplication, then fills
// the result register from the command register. One tick can be accepted
// every cycle while item_stall is low, as crsc_step is combinational.
// When the receiver stalls, the result register holds and the command
// register still takes one more tick; item_stall rises only when both are
// full. Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
// always ready and are meant to happen while no tick is in flight; indexes
// above 5 are ignored. Reset is asynchronous: the carriage is stopped with a
// forward heading, the timer and requests are cleared, the bridge is off and
// the registers return to their default values.
// ----------------------------------------------------------------------------
`include "carriage_ramp_stop_controller_defines.svh"

module carriage_ramp_stop_controller
    import crsc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,

    input  logic              item_valid,
    output logic              item_stall,
    input  logic [19:0]       elapsed_us,
    input  logic              at_track_end,
    input  logic              at_track_start,
    input  logic              forward_request,
    input  logic              reverse_request,

    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        motor_speed,
    output logic signed [2:0] bridge_code,
    output logic [1:0]        run_state,
    output logic signed [1:0] travel_direction
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [15:0]          gain_mult;

    mode_t                mode_reg;
    mode_t                mode_next;
    logic [TIME_BITS-1:0] phase_reg;
    logic [TIME_BITS-1:0] phase_next;
    logic [1:0]           heading_reg;
    logic [1:0]           heading_next;
    logic                 pend_fwd_reg;
    logic                 pend_fwd_next;
    logic                 pend_rev_reg;
    logic                 pend_rev_next;

    drive_cmd_t           cmd_next;
    drive_cmd_t           cmd_reg;
    logic [1:0]           cmd_state_reg;
    logic [1:0]           cmd_heading_reg;
    logic                 cmd_valid_reg;

    logic                 result_valid_reg;
    logic [7:0]           speed_reg;
    logic [2:0]           code_reg;
    logic [1:0]           state_reg;
    logic [1:0]           dir_reg;

    logic                 item_take;
    logic                 cmd_move;
    logic [DIV_PROD_BITS-1:0] div_prod;
    logic [7:0]           ramp_level;

    // Configuration: the ramp gain product is refreshed with each write.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next  = cfg_reg;
        gain_mult = 16'(cfg_reg.accel_factor) * 16'(cfg_reg.cruise_level);
        case (cfg_index)
            REG_ACCEL_FACTOR:
            begin
                cfg_next.accel_factor = cfg_data[7:0];
                gain_mult             = 16'(cfg_data[7:0]) * 16'(cfg_reg.cruise_level);
            end
            REG_CRUISE_LEVEL:
            begin
                cfg_next.cruise_level = cfg_data[7:0];
                gain_mult             = 16'(cfg_reg.accel_factor) * 16'(cfg_data[7:0]);
            end
            REG_BRAKE_SPAN:     cfg_next.brake_span     = cfg_data;
            REG_TIMEOUT_LIMIT:  cfg_next.timeout_limit  = cfg_data;
            REG_TIMEOUT_ENABLE: cfg_next.timeout_enable = cfg_data[0];
            REG_TEST_MODE:      cfg_next.test_mode      = cfg_data[0];
            default:            cfg_next = cfg_reg;
        endcase
        cfg_next.ramp_gain = gain_mult;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_factor   <= ACCEL_FACTOR_RESET;
            cfg_reg.cruise_level   <= CRUISE_LEVEL_RESET;
            cfg_reg.brake_span     <= BRAKE_SPAN_RESET;
            cfg_reg.timeout_limit  <= TIMEOUT_LIMIT_RESET;
            cfg_reg.timeout_enable <= 1'b0;
            cfg_reg.test_mode      <= 1'b1;
            cfg_reg.ramp_gain      <= RAMP_GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake: the command register moves on whenever the result register
    // is empty or being emptied.
    assign cmd_move   = cmd_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = cmd_valid_reg && !cmd_move;
    assign item_take  = item_valid && !item_stall;

    crsc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cfg             (cfg_reg),
        .mode_in         (mode_reg),
        .phase_in        (phase_reg),
        .heading_in      (heading_reg),
        .pend_fwd_in     (pend_fwd_reg),
        .pend_rev_in     (pend_rev_reg),
        .elapsed_us      (elapsed_us),
        .at_track_end    (at_track_end),
        .at_track_start  (at_track_start),
        .forward_request (forward_request),
        .reverse_request (reverse_request),
        .mode_out        (mode_next),
        .phase_out       (phase_next),
        .heading_out     (heading_next),
        .pend_fwd_out    (pend_fwd_next),
        .pend_rev_out    (pend_rev_next),
        .cmd             (cmd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_STOPPED;
            phase_reg     <= '0;
            heading_reg   <= HEAD_FWD;
            pend_fwd_reg  <= 1'b0;
            pend_rev_reg  <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                mode_reg     <= mode_next;
                phase_reg    <= phase_next;
                heading_reg  <= heading_next;
                pend_fwd_reg <= pend_fwd_next;
                pend_rev_reg <= pend_rev_next;
            end
            if (item_take)
                cmd_valid_reg <= 1'b1;
            else if (cmd_move)
                cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg         <= cmd_next;
            cmd_state_reg   <= mode_code(mode_next);
            cmd_heading_reg <= heading_next;
        end
    end

    // Ramp level: numerator / 390625 by reciprocal multiplication.
    assign div_prod   = DIV_PROD_BITS'(cmd_reg.level_num) * DIV_PROD_BITS'(RECIP);
    assign ramp_level = div_prod[RECIP_SHIFT+7:RECIP_SHIFT];

    // The result register doubles as the bridge hold: its level and code change
    // only when a tick drives the bridge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            speed_reg        <= '0;
            code_reg         <= CODE_OFF;
            state_reg        <= RUN_STOPPED;
            dir_reg          <= HEAD_FWD;
        end
        else
        begin
            if (cmd_move)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= cmd_state_reg;
                dir_reg          <= cmd_heading_reg;
                if (cmd_reg.drive)
                begin
                    speed_reg <= cmd_reg.use_level ? ramp_level : cmd_reg.speed;
                    code_reg  <= cmd_reg.code;
                end
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid     = result_valid_reg;
    assign motor_speed      = speed_reg;
    assign bridge_code      = $signed(code_reg);
    assign run_state        = state_reg;
    assign travel_direction = $signed(dir_reg);

    // A moving carriage always has a direction.
    `CRSC_ASSERT_SAME(a_moving_heading,
        (mode_reg == ST_RAMP || mode_reg == ST_TRANSIT), (heading_reg != HEAD_NONE))
    // From standstill the only way out is a new ramp.
    `CRSC_ASSERT_NEXT(a_stopped_exit, (item_take && mode_reg == ST_STOPPED),
        (mode_reg == ST_STOPPED || mode_reg == ST_RAMP))
    // A divided ramp level always lies below the top speed, hence below 255.
    `CRSC_ASSERT_SAME(a_level_range,
        (cmd_valid_reg && cmd_reg.drive && cmd_reg.use_level),
        (cmd_reg.level_num < LEVEL_NUM_LIMIT))

endmodule

[test/tb_carriage_ramp_stop_controller.sv]
// ----------------------------------------------------------------------------
// Carriage ramp/stop controller testbench
// Sends control ticks with random gaps and result stalls. Each result is
// checked field by field against a tick-level model of the state machine
// that runs alongside the design and holds its own copy of the registers.
// ----------------------------------------------------------------------------
module tb_carriage_ramp_stop_controller
    import crsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TIME_BITS     = 32;
    localparam logic [63:0] TIME_MAX      = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [63:0] SPEED_DIVIDER = 64'd100000000 >> 8;
    localparam int          PIPE_LATENCY  = 2;
    localparam logic [2:0]  REG_SPARE     = 3'd7;
    localparam logic [19:0] ELAPSED_MAX   = 20'hFFFFF;

    typedef struct packed {
        logic [19:0] elapsed;
        logic        at_end;
        logic        at_start;
        logic        fwd;
        logic        rev;
    } tick_t;

    typedef struct packed {
        logic [7:0] speed;
        logic [2:0] code;
        logic [1:0] state;
        logic [1:0] dir;
    } bridge_report_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;
    logic              item_valid;
    logic              item_stall;
    logic [19:0]       elapsed_us;
    logic              at_track_end;
    logic              at_track_start;
    logic              forward_request;
    logic              reverse_request;
    logic              result_valid;
    logic              result_stall;
    logic [7:0]        motor_speed;
    logic signed [2:0] bridge_code;
    logic [1:0]        run_state;
    logic signed [1:0] travel_direction;

    // Model of the carriage, starting from its reset state.
    logic [1:0]  carriage_mode = RUN_STOPPED;
    logic [63:0] phase_us      = '0;
    int          heading       = 1;
    bit          want_forward  = 1'b0;
    bit          want_reverse  = 1'b0;
    logic [7:0]  held_speed    = '0;
    int          held_code     = 0;

    logic [7:0]  accel_setting         = ACCEL_FACTOR_RESET;
    logic [7:0]  cruise_setting        = CRUISE_LEVEL_RESET;
    logic [31:0] brake_setting         = BRAKE_SPAN_RESET;
    logic [31:0] timeout_limit_setting = TIMEOUT_LIMIT_RESET;
    bit          timeout_enable_setting = 1'b0;
    bit          test_mode_setting      = 1'b1;

    bridge_report_t awaited_reports[$];
    int             mismatch_count = 0;
    bit             idling = 1'b1;
    int             hold_off_cycles = 0;

    carriage_ramp_stop_controller #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .elapsed_us       (elapsed_us),
        .at_track_end     (at_track_end),
        .at_track_start   (at_track_start),
        .forward_request  (forward_request),
        .reverse_request  (reverse_request),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .motor_speed      (motor_speed),
        .bridge_code      (bridge_code),
        .run_state        (run_state),
        .travel_direction (travel_direction)
    );

    always #1 clk = ~clk;

    function automatic void launch_ramp(input int dir);
        phase_us = '0;
        carriage_mode = RUN_RAMP;
        heading = dir;
    endfunction

    function automatic bridge_report_t advance_carriage(input tick_t t);
        logic [63:0]    prod;
        logic [63:0]    quot;
        logic [7:0]     level;
        bit             halt;
        bridge_report_t r;
        if (t.fwd)
            want_forward = 1'b1;
        if (t.rev)
            want_reverse = 1'b1;
        if (phase_us > TIME_MAX - 64'(t.elapsed))
            phase_us = TIME_MAX;
        else
            phase_us = phase_us + 64'(t.elapsed);

        case (carriage_mode)
            RUN_STOPPED:
                heading = 0;
            RUN_RAMP:
            begin
                prod  = (phase_us >> 8) * 64'(accel_setting) * 64'(cruise_setting);
                quot  = prod / SPEED_DIVIDER;
                level = (quot > 64'd255) ? 8'd255 : quot[7:0];
                held_speed = level;
                held_code  = heading;
                if (level >= cruise_setting)
                begin
                    carriage_mode = RUN_TRANSIT;
                    held_speed = cruise_setting;
                end
            end
            RUN_STOPPING:
            begin
                held_speed = '0;
                held_code  = heading + heading;
                if (phase_us >= 64'(brake_setting))
                begin
                    carriage_mode = RUN_STOPPED;
                    phase_us  = '0;
                    held_code = 0;
                end
            end
            default: ;
        endcase

        // A second stop condition on the same tick only clears the timer again.
        if (carriage_mode == RUN_TRANSIT || carriage_mode == RUN_RAMP)
        begin
            halt = (heading > 0 && t.at_end) || (heading < 0 && t.at_start) ||
                   (timeout_enable_setting && phase_us >= 64'(timeout_limit_setting));
            if (halt)
            begin
                phase_us = '0;
                carriage_mode = RUN_STOPPING;
            end
        end

        if (carriage_mode == RUN_STOPPED)
        begin
            if (test_mode_setting)
            begin
                // The heading still holds its old value on the tick that braking ends.
                if (phase_us >= 64'(timeout_limit_setting))
                begin
                    if (heading >= 0)
                        want_reverse = 1'b1;
                    else
                        want_forward = 1'b1;
                    phase_us = '0;
                end
                if (t.at_end)
                    launch_ramp(-1);
                if (t.at_start)
                    launch_ramp(1);
            end
            if (want_forward)
            begin
                want_forward = 1'b0;
                launch_ramp(1);
            end
            if (want_reverse)
            begin
                want_reverse = 1'b0;
                launch_ramp(-1);
            end
        end

        r.speed = held_speed;
        r.code  = 3'(held_code);
        r.state = carriage_mode;
        r.dir   = 2'(heading);
        return r;
    endfunction

    function automatic tick_t make_tick(input logic [19:0] elapsed, input bit at_end,
                                        input bit at_start, input bit fwd, input bit rev);
        tick_t t;
        t.elapsed  = elapsed;
        t.at_end   = at_end;
        t.at_start = at_start;
        t.fwd      = fwd;
        t.rev      = rev;
        return t;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 10)
            t.elapsed = '0;
        else if (sel < 40)
            t.elapsed = 20'($urandom_range(4095));
        else if (sel < 90)
            t.elapsed = 20'($urandom);
        else
            t.elapsed = ELAPSED_MAX;
        t.at_end   = ($urandom_range(99) < 8);
        t.at_start = ($urandom_range(99) < 8);
        t.fwd      = ($urandom_range(99) < 6);
        t.rev      = ($urandom_range(99) < 6);
        return t;
    endfunction

    function automatic logic [31:0] pick_setting(input logic [31:0] top,
                                                 input logic [31:0] usual);
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return '0;
        else if (sel < 20)
            return top;
        else
            return 32'($urandom_range(usual));
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] expv,
                                        input logic signed [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatch_count++;
        end
    endfunction

    // All driving tasks start and end on a falling edge.
    task automatic send_tick(input tick_t t);
        while (idling && $urandom_range(99) < 16)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid      <= 1'b1;
        elapsed_us      <= t.elapsed;
        at_track_end    <= t.at_end;
        at_track_start  <= t.at_start;
        forward_request <= t.fwd;
        reverse_request <= t.rev;
        do
        begin
            @(posedge clk);
        end
        while (item_stall !== 1'b0);
        awaited_reports.push_back(advance_carriage(t));
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        case (index)
            REG_ACCEL_FACTOR:   accel_setting          = data[7:0];
            REG_CRUISE_LEVEL:   cruise_setting         = data[7:0];
            REG_BRAKE_SPAN:     brake_setting          = data;
            REG_TIMEOUT_LIMIT:  timeout_limit_setting  = data;
            REG_TIMEOUT_ENABLE: timeout_enable_setting = data[0];
            REG_TEST_MODE:      test_mode_setting      = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Reset settings: a forward run ramps to cruise, takes a reverse request
    // while moving, brakes at the track end and then leaves in reverse.
    task automatic test_default_run();
        send_tick(make_tick('0, 0, 0, 0, 0));
        send_tick(make_tick(20'd1000, 0, 0, 1, 0));
        repeat (5) send_tick(make_tick(ELAPSED_MAX, 0, 0, 0, 0));
        send_tick(make_tick(20'd10, 0, 0, 0, 1));
        send_tick(make_tick(20'd10, 1, 0, 0, 0));
        repeat (8) send_tick(make_tick(ELAPSED_MAX, 0, 0, 0, 0));
    endtask

    // Ramp level clamped at full scale, zero braking time and zero top speed.
    task automatic test_ramp_extremes();
        drain_results();
        write_reg(REG_ACCEL_FACTOR, 32'hFFFFFFFF);
        write_reg(REG_CRUISE_LEVEL, 32'd255);
        write_reg(REG_BRAKE_SPAN, '0);
        write_reg(REG_TIMEOUT_LIMIT, 32'hFFFFFFFF);
        write_reg(REG_TIMEOUT_ENABLE, 32'd1);
        write_reg(REG_TEST_MODE, '0);
        write_reg(REG_SPARE, 32'hFFFFFFFF);
        send_tick(make_tick(ELAPSED_MAX, 0, 1, 0, 0));
        send_tick(make_tick('0, 0, 0, 0, 0));
        send_tick(make_tick(ELAPSED_MAX, 0, 0, 1, 0));
        send_tick(make_tick(ELAPSED_MAX, 0, 0, 0, 0));
        drain_results();
        write_reg(REG_CRUISE_LEVEL, '0);
        send_tick(make_tick('0, 1, 0, 0, 0));
        send_tick(make_tick('0, 0, 0, 0, 1));
        send_tick(make_tick('0, 0, 0, 0, 0));
        send_tick(make_tick('0, 0, 1, 0, 0));
        send_tick(make_tick('0, 0, 0, 0, 0));
    endtask

    // Both requests at once, both sensors while stopped, the idle reverse
    // including the tick on which braking ends, and the travel timeout.
    task automatic test_requests_and_sensors();
        drain_results();
        write_reg(REG_ACCEL_FACTOR, 32'd20);
        write_reg(REG_CRUISE_LEVEL, 32'd200);
        write_reg(REG_TIMEOUT_LIMIT, '0);
        write_reg(REG_TIMEOUT_ENABLE, '0);
        write_reg(REG_TEST_MODE, 32'd1);
        send_tick(make_tick(20'd5, 0, 0, 1, 1));
        send_tick(make_tick(20'd100, 0, 1, 0, 0));
        send_tick(make_tick('0, 0, 0, 0, 0));
        send_tick(make_tick('0, 1, 0, 0, 0));
        send_tick(make_tick('0, 0, 0, 0, 0));
        drain_results();
        write_reg(REG_TIMEOUT_LIMIT, 32'd3000000);
        send_tick(make_tick('0, 0, 1, 0, 0));
        send_tick(make_tick('0, 0, 0, 0, 0));
        send_tick(make_tick('0, 1, 1, 0, 0));
        drain_results();
        write_reg(REG_TIMEOUT_ENABLE, 32'd1);
        repeat (4) send_tick(make_tick(ELAPSED_MAX, 0, 0, 0, 0));
    endtask

    // Braking with the largest braking time, so that the phase timer grows
    // over many long ticks while the carriage keeps braking.
    task automatic test_long_braking();
        int guard;
        drain_results();
        write_reg(REG_TEST_MODE, '0);
        write_reg(REG_BRAKE_SPAN, '0);
        write_reg(REG_TIMEOUT_ENABLE, '0);
        guard = 0;
        while (!(carriage_mode == RUN_STOPPED && !want_forward && !want_reverse) &&
               guard < 10)
        begin
            send_tick(make_tick('0, 1, 1, 0, 0));
            guard++;
        end
        drain_results();
        write_reg(REG_BRAKE_SPAN, 32'hFFFFFFFF);
        send_tick(make_tick('0, 0, 0, 1, 0));
        send_tick(make_tick('0, 1, 0, 0, 0));
        guard = 0;
        while (carriage_mode == RUN_STOPPING && guard < 40)
        begin
            send_tick(make_tick(ELAPSED_MAX, 0, 0, 0, 0));
            guard++;
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while ticks keep being offered back to back.
    task automatic test_backpressure();
        drain_results();
        write_reg(REG_BRAKE_SPAN, 32'd2000000);
        write_reg(REG_TEST_MODE, 32'd1);
        idling = 1'b0;
        hold_off_cycles = 40;
        repeat (30) send_tick(random_tick());
        drain_results();
        idling = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            write_reg(REG_ACCEL_FACTOR, pick_setting(32'd255, 32'd255));
            write_reg(REG_CRUISE_LEVEL, pick_setting(32'd255, 32'd255));
            write_reg(REG_BRAKE_SPAN, pick_setting(32'hFFFFFFFF, 32'd3000000));
            write_reg(REG_TIMEOUT_LIMIT, pick_setting(32'hFFFFFFFF, 32'd12000000));
            write_reg(REG_TIMEOUT_ENABLE, pick_setting(32'd1, 32'd1));
            write_reg(REG_TEST_MODE, pick_setting(32'd1, 32'd1));
            // One phase runs without any gaps or stalls.
            idling = (phase != 3);
            repeat (200) send_tick(random_tick());
        end
        idling = 1'b1;
    endtask

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_off_cycles--;
            end
            else
                result_stall <= idling && ($urandom_range(99) < 16);
        end
    end

    always @(posedge clk)
    begin
        bridge_report_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("result arrived with no tick outstanding");
                mismatch_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("motor_speed", 32'(want.speed), 32'(motor_speed));
                check_field("bridge_code", 32'($signed(want.code)), 32'(bridge_code));
                check_field("run_state", 32'(want.state), 32'(run_state));
                check_field("travel_direction", 32'($signed(want.dir)),
                            32'(travel_direction));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_valid      = 1'b0;
        elapsed_us      = '0;
        at_track_end    = 1'b0;
        at_track_start  = 1'b0;
        forward_request = 1'b0;
        reverse_request = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_run();
        test_ramp_extremes();
        test_requests_and_sensors();
        test_long_braking();
        test_backpressure();
        test_random_phases();
        drain_results();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
